// ===== hw/rtl/lbks_pkg.sv =====
// Shared constants, read-address select codes and the command/status structs
// for the lower-bound key search block. No dependencies.
package lbks_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int SIZE_W      = ADDR_W + 1;
   localparam int CFG_W       = 11;
   localparam int KEY_W       = 32;

   // Smallest first word that lets a set select flag pick the second word.
   localparam logic signed [KEY_W-1:0] SELECT_MIN = 32'sd2;

   // Read-address select codes for the key memory.
   localparam logic [1:0] RD_MID   = 2'd0;
   localparam logic [1:0] RD_PROBE = 2'd1;
   localparam logic [1:0] RD_BACK1 = 2'd2;
   localparam logic [1:0] RD_BACK2 = 2'd3;

   typedef struct packed {
      logic       load_wr;
      logic       init;
      logic       probe_update;
      logic       mark_hit;
      logic       step_back;
      logic       publish;
      logic [1:0] rd_sel;
   } cmd_type;

   typedef struct packed {
      logic range_nz;
      logic probe_more;
      logic probe_in;
      logic key_eq;
      logic lo_nz;
      logic lo_gt1;
   } sts_type;

endpackage

// ===== hw/rtl/lower_bound_key_search.sv =====
// Lower-bound key search: a 1024-entry table of signed keys searched by binary search.
// A load is written in the cycle it is accepted. A search sets up the bounds, then makes
// one probe per cycle (up to 11 probes for a full table), checks the landing entry and
// scans backward over equal neighbors; the single-port key memory read sets that pace.
// One transaction is worked at a time: a new request is taken only once the last is done.
// Synchronous reset clears the control state and table_size; key memory is not cleared.
module lower_bound_key_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [lbks_pkg::ADDR_W-1:0]           req_slot,
   input  logic signed [lbks_pkg::KEY_W-1:0]     req_first_word,
   input  logic signed [lbks_pkg::KEY_W-1:0]     req_second_word,
   input  logic                                  req_select_flag,
   input  logic signed [lbks_pkg::KEY_W-1:0]     req_search_key,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic [lbks_pkg::ADDR_W-1:0]           rsp_position,
   input  logic                                  csr_wr_en,
   input  logic [lbks_pkg::CFG_W-1:0]            csr_wr_data
);

   // The controller issues one command word per cycle; the datapath answers with compare
   // status from the registered memory read and bound status from the search bounds.
   lbks_pkg::cmd_type cmd;
   lbks_pkg::sts_type sts;

   // The controller owns the handshakes and the sequencing. A load is written
   // into the key memory in the cycle it is accepted. A search walks the
   // bounds with one probe per cycle, checks the landing entry for equality
   // and then steps backward over neighbors holding the same key.
   lbks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the key memory, the table size register, the search
   // bounds and the result register that drives the response fields.
   lbks_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_slot        (req_slot),
      .req_first_word  (req_first_word),
      .req_second_word (req_second_word),
      .req_select_flag (req_select_flag),
      .req_search_key  (req_search_key),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule

// ===== hw/rtl/lbks_dp.sv =====
// Datapath of the lower-bound key search: key memory, search bounds, compare
// logic and result register. Depends on lbks_pkg.
module lbks_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lbks_pkg::cmd_type                     cmd,
   output lbks_pkg::sts_type                     sts,
   input  logic                                  csr_wr_en,
   input  logic [lbks_pkg::CFG_W-1:0]            csr_wr_data,
   input  logic [lbks_pkg::ADDR_W-1:0]           req_slot,
   input  logic signed [lbks_pkg::KEY_W-1:0]     req_first_word,
   input  logic signed [lbks_pkg::KEY_W-1:0]     req_second_word,
   input  logic                                  req_select_flag,
   input  logic signed [lbks_pkg::KEY_W-1:0]     req_search_key,
   output logic                                  rsp_found,
   output logic [lbks_pkg::ADDR_W-1:0]           rsp_position
);

   logic [lbks_pkg::KEY_W-1:0]  key_mem [lbks_pkg::MAX_ENTRIES];
   logic [lbks_pkg::KEY_W-1:0]  rdata_ff;
   logic [lbks_pkg::ADDR_W-1:0] rd_addr;

   logic [lbks_pkg::CFG_W-1:0]  table_size_ff;
   logic [lbks_pkg::SIZE_W-1:0] lo_ff;
   logic [lbks_pkg::SIZE_W-1:0] hi_ff;
   logic signed [lbks_pkg::KEY_W-1:0] key_ff;
   logic                        hit_ff;
   logic                        rsp_found_ff;
   logic [lbks_pkg::ADDR_W-1:0] rsp_position_ff;

   logic [lbks_pkg::SIZE_W-1:0] size_c;
   logic [lbks_pkg::SIZE_W-1:0] mid_c;
   logic [lbks_pkg::SIZE_W-1:0] lo_nx;
   logic [lbks_pkg::SIZE_W-1:0] hi_nx;
   logic [lbks_pkg::SIZE_W-1:0] mid_nx;
   logic [lbks_pkg::SIZE_W:0]   sum_c;
   logic [lbks_pkg::SIZE_W:0]   sum_nx;
   logic                        less_c;
   logic [lbks_pkg::KEY_W-1:0]  eff_key;

   // Sizes above the table depth are searched as a full table.
   always_comb begin
      if (table_size_ff > lbks_pkg::CFG_W'(lbks_pkg::MAX_ENTRIES)) begin
         size_c = lbks_pkg::SIZE_W'(lbks_pkg::MAX_ENTRIES);
      end else begin
         size_c = lbks_pkg::SIZE_W'(table_size_ff);
      end
   end

   assign eff_key = (req_select_flag && (req_first_word >= lbks_pkg::SELECT_MIN))
                    ? req_second_word : req_first_word;

   assign sum_c  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c  = sum_c[lbks_pkg::SIZE_W:1];
   assign less_c = $signed(rdata_ff) < key_ff;
   assign lo_nx  = less_c ? (mid_c + lbks_pkg::SIZE_W'(1)) : lo_ff;
   assign hi_nx  = less_c ? hi_ff : mid_c;
   assign sum_nx = {1'b0, lo_nx} + {1'b0, hi_nx};
   assign mid_nx = sum_nx[lbks_pkg::SIZE_W:1];

   always_comb begin
      case (cmd.rd_sel)
         lbks_pkg::RD_MID: begin
            rd_addr = mid_c[lbks_pkg::ADDR_W-1:0];
         end
         lbks_pkg::RD_PROBE: begin
            if (lo_nx < hi_nx) begin
               rd_addr = mid_nx[lbks_pkg::ADDR_W-1:0];
            end else begin
               rd_addr = lo_nx[lbks_pkg::ADDR_W-1:0];
            end
         end
         lbks_pkg::RD_BACK1: begin
            rd_addr = lo_ff[lbks_pkg::ADDR_W-1:0] - lbks_pkg::ADDR_W'(1);
         end
         lbks_pkg::RD_BACK2: begin
            rd_addr = lo_ff[lbks_pkg::ADDR_W-1:0] - lbks_pkg::ADDR_W'(2);
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_comb begin
      sts.range_nz   = lo_ff < hi_ff;
      sts.probe_more = lo_nx < hi_nx;
      sts.probe_in   = lo_nx < size_c;
      sts.key_eq     = rdata_ff == key_ff;
      sts.lo_nz      = lo_ff != '0;
      sts.lo_gt1     = lo_ff > lbks_pkg::SIZE_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         key_mem[req_slot] <= eff_key;
      end
      rdata_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else if (csr_wr_en) begin
         table_size_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         lo_ff  <= '0;
         hi_ff  <= size_c;
         key_ff <= req_search_key;
         hit_ff <= 1'b0;
      end else begin
         if (cmd.probe_update) begin
            lo_ff <= lo_nx;
            hi_ff <= hi_nx;
         end else if (cmd.step_back) begin
            lo_ff <= lo_ff - lbks_pkg::SIZE_W'(1);
         end
         if (cmd.mark_hit) begin
            hit_ff <= 1'b1;
         end
      end
      if (cmd.publish) begin
         rsp_found_ff    <= hit_ff;
         rsp_position_ff <= hit_ff ? lo_ff[lbks_pkg::ADDR_W-1:0] : '0;
      end
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== hw/rtl/lbks_ctrl.sv =====
// Controller state machine of the lower-bound key search: sequences loads,
// binary-search probes, the backward scan and the result handshake.
// Depends on lbks_pkg.
module lbks_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  lbks_pkg::sts_type sts,
   output lbks_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_PROBE = 3'd2;
   localparam logic [2:0] S_EQ    = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   localparam logic OP_SEARCH = 1'b1;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = lbks_pkg::RD_MID;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_SEARCH) begin
                  cmd.init = 1'b1;
                  state_in = S_START;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_START: begin
            cmd.rd_sel = lbks_pkg::RD_MID;
            state_in   = sts.range_nz ? S_PROBE : S_DONE;
         end
         S_PROBE: begin
            cmd.probe_update = 1'b1;
            cmd.rd_sel       = lbks_pkg::RD_PROBE;
            if (sts.probe_more) begin
               state_in = S_PROBE;
            end else if (sts.probe_in) begin
               state_in = S_EQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_EQ: begin
            cmd.rd_sel = lbks_pkg::RD_BACK1;
            if (sts.key_eq) begin
               cmd.mark_hit = 1'b1;
               state_in     = sts.lo_nz ? S_SCAN : S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.rd_sel = lbks_pkg::RD_BACK2;
            if (sts.key_eq) begin
               cmd.step_back = 1'b1;
               state_in      = sts.lo_gt1 ? S_SCAN : S_DONE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== dv/tb_lower_bound_key_search.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lower_bound_key_search: directed rows, then random segments.
// Depends on lbks_pkg and the lower_bound_key_search RTL; reads no files.
module tb_lower_bound_key_search;

   localparam int ADDR_W      = lbks_pkg::ADDR_W;
   localparam int CFG_W       = lbks_pkg::CFG_W;
   localparam int KEY_W       = lbks_pkg::KEY_W;
   localparam int MAX_ENTRIES = lbks_pkg::MAX_ENTRIES;

   // Opcodes of the req_op field.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam longint KEY_MIN_L = -64'sd2147483648;
   localparam longint KEY_MAX_L = 64'sd2147483647;
   localparam int CFG_MAX = (1 << CFG_W) - 1;

   // Before a register write we let the block finish any load still in flight;
   // the same pause closes the run.
   localparam int DRAIN_CYCLES = 40;
   // Worst case with no handshake at all: a backward scan over the whole table,
   // a long sender gap and a long receiver stall, taken several times over.
   localparam int WATCHDOG_CYCLES = 6000;
   localparam int MAX_REPORTS = 10;

   typedef enum {ROW_LOAD, ROW_SEARCH, ROW_SIZE} row_kind_type;

   typedef struct packed {
      logic                    op;
      logic [ADDR_W-1:0]       slot;
      logic signed [KEY_W-1:0] first_word;
      logic signed [KEY_W-1:0] second_word;
      logic                    select_flag;
      logic signed [KEY_W-1:0] search_key;
      // Set on directed searches whose answer is written into the table.
      logic                    typed;
      logic                    typed_found;
      logic [ADDR_W-1:0]       typed_position;
   } lookup_req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] position;
   } lookup_result_type;

   typedef struct {
      row_kind_type            kind;
      logic [ADDR_W-1:0]       slot;
      logic                    flag;
      logic signed [KEY_W-1:0] first_word;
      logic signed [KEY_W-1:0] second_word;
      logic signed [KEY_W-1:0] key;
      logic                    typed;
      logic                    found;
      logic [ADDR_W-1:0]       position;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_op = OP_LOAD;
   logic [ADDR_W-1:0]       req_slot = '0;
   logic signed [KEY_W-1:0] req_first_word = '0;
   logic signed [KEY_W-1:0] req_second_word = '0;
   logic                    req_select_flag = 1'b0;
   logic signed [KEY_W-1:0] req_search_key = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_found;
   logic [ADDR_W-1:0]       rsp_position;
   logic                    csr_wr_en = 1'b0;
   logic [CFG_W-1:0]        csr_wr_data = '0;

   // Our own picture of the block: effective keys and the table size register.
   logic signed [KEY_W-1:0] key_mirror [MAX_ENTRIES];
   bit                      slot_loaded [MAX_ENTRIES];
   logic [CFG_W-1:0]        size_mirror = '0;

   lookup_result_type pending_results [$];
   stim_row_type      directed_rows [$];
   lookup_req_type    cur_req;
   int unsigned    items_sent = 0;
   int unsigned    fail_count = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    stall_left = 0;
   // When set, neither side inserts gaps, so the block sees back-to-back traffic.
   bit             calm_mode = 1'b0;

   lower_bound_key_search u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_first_word  (req_first_word),
      .req_second_word (req_second_word),
      .req_select_flag (req_select_flag),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm_mode || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Lower-bound binary search over the mirrored table, then a backward walk
   // over equal neighbors so that the first slot holding the key is reported.
   function automatic lookup_result_type lower_bound_lookup(
         input logic signed [KEY_W-1:0] key);
      lookup_result_type res;
      int unsigned    span, lo, hi, mid;
      span = (size_mirror > MAX_ENTRIES) ? MAX_ENTRIES : size_mirror;
      lo = 0;
      hi = span;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (key_mirror[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      res = '0;
      if (lo < span && key_mirror[lo] == key) begin
         while (lo > 0 && key_mirror[lo - 1] == key) lo--;
         res.found    = 1'b1;
         res.position = lo[ADDR_W-1:0];
      end
      return res;
   endfunction

   // Number of slots loaded contiguously from slot 0; searches never reach past it.
   function automatic int unsigned loaded_prefix();
      int unsigned k;
      k = 0;
      while (k < MAX_ENTRIES && slot_loaded[k]) k++;
      return k;
   endfunction

   // Fields that an operation ignores are filled with noise.
   function automatic lookup_req_type make_load(input logic [ADDR_W-1:0] slot,
                                                input logic flag,
                                                input logic signed [KEY_W-1:0] first_word,
                                                input logic signed [KEY_W-1:0] second_word);
      lookup_req_type it;
      it             = '0;
      it.op          = OP_LOAD;
      it.slot        = slot;
      it.select_flag = flag;
      it.first_word  = first_word;
      it.second_word = second_word;
      it.search_key  = $urandom();
      return it;
   endfunction

   function automatic lookup_req_type make_search(input logic signed [KEY_W-1:0] key);
      lookup_req_type it;
      it             = '0;
      it.op          = OP_SEARCH;
      it.search_key  = key;
      it.slot        = ADDR_W'($urandom());
      it.first_word  = $urandom();
      it.second_word = $urandom();
      it.select_flag = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic void add_row(input row_kind_type kind, input int unsigned slot,
                                   input logic flag, input logic signed [KEY_W-1:0] first_word,
                                   input logic signed [KEY_W-1:0] second_word,
                                   input logic signed [KEY_W-1:0] key, input logic typed,
                                   input logic found, input int unsigned position);
      stim_row_type row;
      row.kind        = kind;
      row.slot        = ADDR_W'(slot);
      row.flag        = flag;
      row.first_word  = first_word;
      row.second_word = second_word;
      row.key         = key;
      row.typed       = typed;
      row.found       = found;
      row.position    = ADDR_W'(position);
      directed_rows.push_back(row);
   endfunction

   // Search keys: mostly keys present in the active table or one off them,
   // sometimes the extremes, the rest anywhere.
   function automatic logic signed [KEY_W-1:0] pick_probe();
      int unsigned span, idx, r;
      span = (size_mirror > MAX_ENTRIES) ? MAX_ENTRIES : size_mirror;
      r = $urandom_range(0, 9);
      idx = (span != 0) ? $urandom_range(0, span - 1) : 0;
      if (span != 0 && r < 4) return key_mirror[idx];
      if (span != 0 && r == 4) return key_mirror[idx] + 1;
      if (span != 0 && r == 5) return key_mirror[idx] - 1;
      if (r == 6) return ($urandom_range(0, 1) == 0) ? KEY_MIN : KEY_MAX;
      return $urandom();
   endfunction

   // Sends one transaction. The valid stays high after acceptance, so that the
   // next call can follow without a gap; hold_until_drained lowers it.
   task automatic issue_item(input lookup_req_type it);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_req          = it;
      req_valid       <= 1'b1;
      req_op          <= it.op;
      req_slot        <= it.slot;
      req_first_word  <= it.first_word;
      req_second_word <= it.second_word;
      req_select_flag <= it.select_flag;
      req_search_key  <= it.search_key;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // The register is only written once the block has nothing left to do.
   task automatic set_table_size(input logic [CFG_W-1:0] value);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      size_mirror  = value;
   endtask

   // Stores a wanted effective key through one of the encodings that yield it:
   // the first word directly, or the second word behind a set select flag.
   task automatic load_entry(input int unsigned slot, input logic signed [KEY_W-1:0] key);
      if ($urandom_range(0, 1) == 0) begin
         issue_item(make_load(ADDR_W'(slot), 1'b0, key, $urandom()));
      end else if (key >= lbks_pkg::SELECT_MIN) begin
         issue_item(make_load(ADDR_W'(slot), 1'b1, $urandom_range(32'h7FFF_FFFF, 2), key));
      end else begin
         issue_item(make_load(ADDR_W'(slot), 1'b1, key, $urandom()));
      end
   endtask

   // Loads slots 0 .. count-1 in shuffled order with a sorted key run that holds
   // duplicates, so the backward scan over equal neighbors gets exercised.
   task automatic fill_sorted(input int unsigned count);
      logic signed [KEY_W-1:0] keys [MAX_ENTRIES];
      int unsigned             order [MAX_ENTRIES];
      longint                  walk;
      int unsigned             r, j, tmp;
      case ($urandom_range(0, 3))
         0: walk = KEY_MIN_L + longint'($urandom_range(0, 3));
         1: walk = longint'($urandom_range(0, 40)) - 20;
         2: walk = KEY_MAX_L - longint'($urandom_range(0, 4 * count));
         default: walk = longint'(int'($urandom()));
      endcase
      for (int i = 0; i < count; i++) begin
         keys[i]  = walk[KEY_W-1:0];
         order[i] = i;
         r = $urandom_range(0, 9);
         if (r < 3) walk += 0;
         else if (r < 7) walk += $urandom_range(1, 3);
         else if (r < 9) walk += $urandom_range(4, 5000);
         else walk += $urandom_range(1, 32'h0FFF_FFFF);
         if (walk > KEY_MAX_L) walk = KEY_MAX_L;
      end
      for (int i = count - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < count; i++) load_entry(order[i], keys[order[i]]);
   endtask

   // Searches, with a few raw loads mixed in (they may break the sort order,
   // which the block has to handle all the same) and an occasional full drain.
   task automatic search_burst(input int unsigned count);
      int unsigned r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 19);
         if (r < 2) begin
            issue_item(make_load(ADDR_W'($urandom_range(0, MAX_ENTRIES - 1)),
                                 1'($urandom_range(0, 1)), $urandom(), $urandom()));
         end else if (r == 2) begin
            hold_until_drained();
         end else begin
            issue_item(make_search(pick_probe()));
         end
      end
   endtask

   task automatic run_small_segment();
      int unsigned entries, lim, r;
      logic [CFG_W-1:0] size;
      calm_mode = ($urandom_range(0, 3) == 0);
      entries = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(25, 128);
      fill_sorted(entries);
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 2))
            issue_item(make_load(ADDR_W'($urandom_range(0, entries + 7)),
                                 1'($urandom_range(0, 1)), $urandom(), $urandom()));
      end
      // Drain first so that every accepted load is marked before the prefix is counted.
      hold_until_drained();
      lim = loaded_prefix();
      r = $urandom_range(0, 9);
      if (r < 6) size = CFG_W'(entries);
      else if (r < 8) size = CFG_W'($urandom_range(0, lim));
      else if (r == 8) size = '0;
      else size = (lim == MAX_ENTRIES) ? CFG_W'($urandom_range(MAX_ENTRIES, CFG_MAX))
                                       : CFG_W'(lim);
      set_table_size(size);
      search_burst($urandom_range(8, 30));
   endtask

   // Receiver side: random stalls of the same shape as the sender's gaps.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Scoreboard. Both channels are sampled at the rising edge. An accepted load
   // updates the mirror; an accepted search queues its expected result, which is
   // either typed into the directed table or worked out by lower_bound_lookup.
   // Every accepted result is compared with the oldest queued one.
   always @(posedge clock) begin : scoreboard
      lookup_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) begin
               key_mirror[req_slot]  = (req_select_flag &&
                                        req_first_word >= lbks_pkg::SELECT_MIN) ?
                                       req_second_word : req_first_word;
               slot_loaded[req_slot] = 1'b1;
            end else if (cur_req.typed) begin
               want.found    = cur_req.typed_found;
               want.position = cur_req.typed_position;
               pending_results.push_back(want);
            end else begin
               pending_results.push_back(lower_bound_lookup(req_search_key));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: unexpected lookup result found=%0d position=%0d",
                           $realtime, rsp_found, rsp_position);
            end else begin
               want = pending_results.pop_front();
               if (rsp_found !== want.found || rsp_position !== want.position) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"%0t: lookup mismatch: expected found=%0d position=%0d,",
                               " got found=%0d position=%0d"},
                              $realtime, want.found, want.position, rsp_found,
                              rsp_position);
               end
            end
         end
         // The watchdog only restarts when a transaction moves on either channel.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      lookup_req_type req;

      // Directed rows. After reset the table size is zero, so every search misses.
      // Slots 0 to 5 then hold the keys MIN, 1, 7, 7, 7, MAX and show each way
      // of forming the effective key: a set flag with a first word below two keeps
      // the first word, a first word of exactly two is the smallest that switches
      // to the second word. Slot 1023 is the top of the slot range.
      //       kind        slot flag first      second     key/size   typed found pos
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd0,    1,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         KEY_MAX,   1,    0,    0);
      add_row(ROW_LOAD,   0,   1,   KEY_MIN,   5,         0,         0,    0,    0);
      add_row(ROW_LOAD,   1,   1,   1,         777,       0,         0,    0,    0);
      add_row(ROW_LOAD,   2,   1,   2,         7,         0,         0,    0,    0);
      add_row(ROW_LOAD,   3,   0,   7,         -9,        0,         0,    0,    0);
      add_row(ROW_LOAD,   4,   1,   3,         7,         0,         0,    0,    0);
      add_row(ROW_LOAD,   5,   1,   KEY_MAX,   KEY_MAX,   0,         0,    0,    0);
      add_row(ROW_LOAD,   1023, 0,  -1,        KEY_MIN,   0,         0,    0,    0);
      add_row(ROW_SIZE,   0,   0,   0,         0,         32'sd6,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         KEY_MIN,   1,    1,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         KEY_MAX,   1,    1,    5);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd7,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd1,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd2,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd5,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd777,  0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         -32'sd9,   0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         KEY_MIN+1, 0,    0,    0);
      add_row(ROW_SIZE,   0,   0,   0,         0,         32'sd3,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         32'sd7,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         KEY_MAX,   0,    0,    0);
      add_row(ROW_SIZE,   0,   0,   0,         0,         32'sd0,    0,    0,    0);
      add_row(ROW_SEARCH, 0,   0,   0,         0,         KEY_MIN,   1,    0,    0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_LOAD: begin
               issue_item(make_load(directed_rows[i].slot, directed_rows[i].flag,
                                    directed_rows[i].first_word, directed_rows[i].second_word));
            end
            ROW_SEARCH: begin
               req                = make_search(directed_rows[i].key);
               req.typed          = directed_rows[i].typed;
               req.typed_found    = directed_rows[i].found;
               req.typed_position = directed_rows[i].position;
               issue_item(req);
            end
            ROW_SIZE: begin
               set_table_size(directed_rows[i].key[CFG_W-1:0]);
            end
            default: begin
            end
         endcase
      end

      // Random part. Small sorted tables first, then one fill of the whole table
      // so that full and oversized size settings become legal, then more small
      // tables that now sit on top of older contents.
      while (items_sent < 100) run_small_segment();

      calm_mode = 1'b0;
      fill_sorted(MAX_ENTRIES);
      set_table_size(CFG_W'(MAX_ENTRIES));
      search_burst(20);
      // The sender waits here for every outstanding result before going on.
      hold_until_drained();
      search_burst(20);
      set_table_size(CFG_W'(CFG_MAX));
      search_burst(15);
      set_table_size(CFG_W'($urandom_range(MAX_ENTRIES + 1, CFG_MAX - 1)));
      search_burst(10);

      while (items_sent < 1300) run_small_segment();

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
